FILE: design/spd_pkg.sv
package spd_pkg;

  // Table geometry and address layout
  localparam int ADDR_BITS    = 40;
  localparam int PAGE_BITS    = 12;
  localparam int UP_ENTRIES   = 8;
  localparam int DOWN_ENTRIES = 8;
  localparam int UP_IW        = (UP_ENTRIES > 1) ? $clog2(UP_ENTRIES) : 1;
  localparam int DN_IW        = (DOWN_ENTRIES > 1) ? $clog2(DOWN_ENTRIES) : 1;
  localparam int LS_W         = 4;
  localparam int LS_RESET     = 6;

  // Configuration port
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam logic REG_LINE_SHIFT = 1'b0;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DECIDE
  } spd_state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } spd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } spd_status_t;

  // True when line number hi is exactly one above line number lo
  function automatic logic line_next(logic [ADDR_BITS-1:0] hi, logic [ADDR_BITS-1:0] lo);
    return (hi != '0) && ((hi - ADDR_BITS'(1)) == lo);
  endfunction

endpackage

FILE: design/spd_ctrl.sv
module spd_ctrl import spd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  spd_status_t status_i,
  output spd_cmd_t    cmd_o
);

  spd_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    in_stall_o    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_DECIDE: begin
        cmd_o.commit = status_i.out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/spd_datapath.sv
module spd_datapath import spd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spd_cmd_t             cmd_i,
  output spd_status_t          status_o,
  input  logic [LS_W-1:0]      line_shift_i,
  input  logic [ADDR_BITS-1:0] access_addr_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic                 prefetch_valid_o,
  output logic [ADDR_BITS-1:0] prefetch_addr_o
);

  // Tables
  logic [ADDR_BITS-1:0] up_last_q  [UP_ENTRIES];
  logic [UP_IW-1:0]     up_order_q [UP_ENTRIES];
  logic [UP_IW-1:0]     up_order_d [UP_ENTRIES];
  logic [ADDR_BITS-1:0] dn_last_q  [DOWN_ENTRIES];
  logic [DN_IW-1:0]     dn_order_q [DOWN_ENTRIES];
  logic [DN_IW-1:0]     dn_order_d [DOWN_ENTRIES];

  // Search results of the captured item
  logic [ADDR_BITS-1:0] addr_q;
  logic                 up_hit_q, up_hit_d, dn_hit_q, dn_hit_d;
  logic [UP_IW-1:0]     up_pos_q, up_pos_d, up_ent_q, up_ent_d;
  logic [DN_IW-1:0]     dn_pos_q, dn_pos_d, dn_ent_q, dn_ent_d;
  logic [ADDR_BITS-1:0] up_haddr_q, up_haddr_d, dn_haddr_q, dn_haddr_d;
  logic [UP_ENTRIES-1:0]   up_pm;
  logic [DOWN_ENTRIES-1:0] dn_pm;

  // Output register
  logic                 out_valid_q, pf_valid_q;
  logic [ADDR_BITS-1:0] pf_addr_q;

  // Decision
  logic [ADDR_BITS-1:0] la, up_lb, dn_lb, line_inc;
  logic                 up_step, dn_step, maybe_up, maybe_down;
  logic                 up_upd_en, dn_upd_en;
  logic [UP_IW-1:0]     up_upd_pos, up_wr_ent;
  logic [DN_IW-1:0]     dn_upd_pos, dn_wr_ent;
  logic                 pf_valid_d;
  logic [ADDR_BITS-1:0] pf_addr_d;

  // Page compare against every entry, then pick the MRU match
  always_comb begin
    for (int e = 0; e < UP_ENTRIES; e++) begin
      up_pm[e] = (up_last_q[e][ADDR_BITS-1:PAGE_BITS] == access_addr_i[ADDR_BITS-1:PAGE_BITS]);
    end
    for (int e = 0; e < DOWN_ENTRIES; e++) begin
      dn_pm[e] = (dn_last_q[e][ADDR_BITS-1:PAGE_BITS] == access_addr_i[ADDR_BITS-1:PAGE_BITS]);
    end
    up_hit_d = 1'b0;
    up_pos_d = '0;
    up_ent_d = '0;
    for (int p = UP_ENTRIES - 1; p >= 0; p--) begin
      if (up_pm[up_order_q[p]]) begin
        up_hit_d = 1'b1;
        up_pos_d = UP_IW'(p);
        up_ent_d = up_order_q[p];
      end
    end
    dn_hit_d = 1'b0;
    dn_pos_d = '0;
    dn_ent_d = '0;
    for (int p = DOWN_ENTRIES - 1; p >= 0; p--) begin
      if (dn_pm[dn_order_q[p]]) begin
        dn_hit_d = 1'b1;
        dn_pos_d = DN_IW'(p);
        dn_ent_d = dn_order_q[p];
      end
    end
    up_haddr_d = '0;
    for (int e = 0; e < UP_ENTRIES; e++) begin
      if (up_ent_d == UP_IW'(e)) up_haddr_d = up_last_q[e];
    end
    dn_haddr_d = '0;
    for (int e = 0; e < DOWN_ENTRIES; e++) begin
      if (dn_ent_d == DN_IW'(e)) dn_haddr_d = dn_last_q[e];
    end
  end

  // Hold the item and its search result
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q     <= access_addr_i;
      up_hit_q   <= up_hit_d;
      up_pos_q   <= up_pos_d;
      up_ent_q   <= up_ent_d;
      up_haddr_q <= up_haddr_d;
      dn_hit_q   <= dn_hit_d;
      dn_pos_q   <= dn_pos_d;
      dn_ent_q   <= dn_ent_d;
      dn_haddr_q <= dn_haddr_d;
    end
  end

  // Line steps and replacement choice
  always_comb begin
    la         = addr_q >> line_shift_i;
    up_lb      = up_haddr_q >> line_shift_i;
    dn_lb      = dn_haddr_q >> line_shift_i;
    line_inc   = ADDR_BITS'(1) << line_shift_i;
    up_step    = up_hit_q && line_next(la, up_lb);
    maybe_down = up_hit_q && line_next(up_lb, la);
    dn_step    = !up_step && dn_hit_q && line_next(dn_lb, la);
    maybe_up   = dn_hit_q && line_next(la, dn_lb);
    up_upd_en  = 1'b0;
    dn_upd_en  = 1'b0;
    up_upd_pos = UP_IW'(UP_ENTRIES - 1);
    dn_upd_pos = DN_IW'(DOWN_ENTRIES - 1);
    up_wr_ent  = up_order_q[UP_ENTRIES - 1];
    dn_wr_ent  = dn_order_q[DOWN_ENTRIES - 1];
    pf_valid_d = 1'b0;
    pf_addr_d  = '0;
    if (up_step) begin
      up_upd_en  = 1'b1;
      up_upd_pos = up_pos_q;
      up_wr_ent  = up_ent_q;
      pf_valid_d = 1'b1;
      pf_addr_d  = addr_q + line_inc;
    end else if (dn_step) begin
      dn_upd_en  = 1'b1;
      dn_upd_pos = dn_pos_q;
      dn_wr_ent  = dn_ent_q;
      pf_valid_d = 1'b1;
      pf_addr_d  = addr_q - line_inc;
    end else if (!up_hit_q && (!dn_hit_q || maybe_up)) begin
      up_upd_en = 1'b1;
    end else if (!dn_hit_q && maybe_down) begin
      dn_upd_en = 1'b1;
    end
  end

  // Move the touched entry to the MRU position
  always_comb begin
    for (int k = 0; k < UP_ENTRIES; k++) begin
      if (k == 0) begin
        up_order_d[k] = up_wr_ent;
      end else if (UP_IW'(k) <= up_upd_pos) begin
        up_order_d[k] = up_order_q[k-1];
      end else begin
        up_order_d[k] = up_order_q[k];
      end
    end
    for (int k = 0; k < DOWN_ENTRIES; k++) begin
      if (k == 0) begin
        dn_order_d[k] = dn_wr_ent;
      end else if (DN_IW'(k) <= dn_upd_pos) begin
        dn_order_d[k] = dn_order_q[k-1];
      end else begin
        dn_order_d[k] = dn_order_q[k];
      end
    end
  end

  // Table update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < UP_ENTRIES; e++) begin
        up_last_q[e]  <= '0;
        up_order_q[e] <= UP_IW'(e);
      end
      for (int e = 0; e < DOWN_ENTRIES; e++) begin
        dn_last_q[e]  <= '0;
        dn_order_q[e] <= DN_IW'(e);
      end
    end else if (cmd_i.commit) begin
      if (up_upd_en) begin
        up_order_q <= up_order_d;
        for (int e = 0; e < UP_ENTRIES; e++) begin
          if (up_wr_ent == UP_IW'(e)) up_last_q[e] <= addr_q;
        end
      end
      if (dn_upd_en) begin
        dn_order_q <= dn_order_d;
        for (int e = 0; e < DOWN_ENTRIES; e++) begin
          if (dn_wr_ent == DN_IW'(e)) dn_last_q[e] <= addr_q;
        end
      end
    end
  end

  // Output register: load on commit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pf_valid_q <= pf_valid_d;
      pf_addr_q  <= pf_addr_d;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign prefetch_valid_o  = pf_valid_q;
  assign prefetch_addr_o   = pf_addr_q;

  // Checks
  a_one_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(up_upd_en && dn_upd_en))
    else $error("both tables updated by one item");

  a_up_mru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && up_upd_en) |=> (up_order_q[0] == $past(up_wr_ent)))
    else $error("updated upward entry is not MRU");

  a_dn_mru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && dn_upd_en) |=> (dn_order_q[0] == $past(dn_wr_ent)))
    else $error("updated downward entry is not MRU");

  a_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !pf_valid_d) |=> (out_valid_q && pf_addr_q == '0))
    else $error("no-prefetch item carries a nonzero address");

endmodule

FILE: design/stream_prefetch_detector.sv
// Stream prefetch detector. Each item carries one demand access address; the block answers
// with exactly one result item, prefetch_valid_o with the next line above (upward stream)
// or below (downward stream) in prefetch_addr_o, or prefetch_valid_o low and a zero
// address. Two 8-entry fully associative LRU tables track the last address per 4 KiB page.
// For each item, the page compare against both tables is done and registered in the accept
// cycle; the line-step check, table/LRU update and result load happen in the decide state,
// once the output register is free. A new item is accepted in the cycle after that result
// is loaded into the output register, so a stalled result holds the block only once a second
// result is ready. The line size is set by the line_shift register at address 0 (reset 6,
// 64-byte lines); write it only while the block is idle.
module stream_prefetch_detector import spd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ADDR_BITS-1:0] access_addr_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 prefetch_valid_o,
  output logic [ADDR_BITS-1:0] prefetch_addr_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  logic [LS_W-1:0] line_shift_q;
  spd_cmd_t        cmd;
  spd_status_t     status;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_shift_q <= LS_W'(LS_RESET);
    end else if (psel && penable && pwrite && (paddr[2] == REG_LINE_SHIFT)) begin
      line_shift_q <= pwdata[LS_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LINE_SHIFT) ? {{(APB_DW-LS_W){1'b0}}, line_shift_q} : '0;

  spd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  spd_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .line_shift_i     (line_shift_q),
    .access_addr_i    (access_addr_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .prefetch_valid_o (prefetch_valid_o),
    .prefetch_addr_o  (prefetch_addr_o)
  );

endmodule
